FILE: rtl/ansi_escape_text_filter_defines.svh
// Assertion macros used by the checker file of the text filter.
// Depends on nothing; every user passes its own clock and reset.
`ifndef ANSI_ESCAPE_TEXT_FILTER_DEFINES_SVH
`define ANSI_ESCAPE_TEXT_FILTER_DEFINES_SVH

// Generic clocked property, disabled while the active-high reset is asserted.
`define AETF_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Condition that must never be seen outside reset.
`define AETF_NEVER(lbl, clk, rst, expr, msg) \
   `AETF_ASSERT(lbl, clk, rst, !(expr), msg)

`endif

FILE: rtl/aetf_pkg.sv
// Shared types and character constants of the ANSI escape text filter.
// Used by the front, back, top level and checker; depends on nothing.
package aetf_pkg;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       end_of_chunk;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic [7:0] repeat_count;
      logic       last_result;
   } rsp_type;

   // main body of one command
   typedef enum logic [1:0] {
      BODY_NONE,
      BODY_BYTE,
      BODY_SPACES,
      BODY_DUMP
   } body_kind_type;

   // one classified input byte, expanded later by the back end
   typedef struct packed {
      logic          esc_lead;    // raw ESC first
      logic [1:0]    crlf_pairs;  // 0..2 CR LF pairs
      body_kind_type body_kind;
      logic [7:0]    body_byte;   // plain byte, or space run length
      logic          esc_tail;    // raw ESC at chunk end
   } cmd_type;

   localparam logic [7:0] ESC_CHAR          = 8'd27;
   localparam logic [7:0] CR_CHAR           = 8'd13;
   localparam logic [7:0] LF_CHAR           = 8'd10;
   localparam logic [7:0] TAB_CHAR          = 8'd9;
   localparam logic [7:0] SPACE_CHAR        = 8'd32;
   localparam logic [7:0] PLUS_CHAR         = 8'd43;
   localparam logic [7:0] MINUS_CHAR        = 8'd45;
   localparam logic [7:0] ZERO_CHAR         = 8'd48;
   localparam logic [7:0] NINE_CHAR         = 8'd57;
   localparam logic [7:0] SEMICOLON_CHAR    = 8'd59;
   localparam logic [7:0] OPEN_BRACKET_CHAR = 8'd91;
   localparam logic [7:0] FINAL_LOW         = 8'd65;
   localparam logic [7:0] FINAL_HIGH        = 8'd127;
   localparam logic [7:0] CMD_CURSOR_POS    = 8'd72;  // 'H'
   localparam logic [7:0] CMD_CURSOR_DOWN   = 8'd66;  // 'B'
   localparam logic [7:0] CMD_CURSOR_FWD    = 8'd67;  // 'C'
   localparam logic [7:0] SPACE_LIMIT_RESET = 8'd80;

endpackage

FILE: rtl/aetf_front.sv
// Front end: parses raw terminal bytes and classifies each into a command.
// Depends on aetf_pkg.
module aetf_front #(
   parameter int CODE_DEPTH = 18
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    accept,
   input  aetf_pkg::req_type       req,
   input  logic                    csr_write,
   input  logic [7:0]              csr_wdata,
   output logic                    cmd_push,
   output aetf_pkg::cmd_type       cmd,
   output logic [CODE_DEPTH*8-1:0] dump
);

   localparam int IDX_W = $clog2(CODE_DEPTH);
   localparam int CNT_W = $clog2(CODE_DEPTH + 1);

   typedef enum logic [1:0] {
      M_NORMAL,
      M_NEWLINE,
      M_SEQ
   } mode_type;

   mode_type         mode_ff, mode_in;
   logic             esc_ff, esc_in;
   logic [7:0]       store_ff [CODE_DEPTH];
   logic [7:0]       store_in [CODE_DEPTH];
   logic [CNT_W-1:0] count_ff, count_in;
   logic [31:0]      prev_row_ff, prev_row_in;
   logic [31:0]      row_ff, row_in;
   logic [31:0]      col_ff, col_in;
   logic [1:0]       field_ff, field_in;
   logic [1:0]       phase_ff, phase_in;
   logic [7:0]       mag_ff, mag_in;
   logic [7:0]       space_limit_ff;

   logic [7:0]       c;
   logic             handle;
   logic             is_digit;
   logic [31:0]      digit;
   logic [CNT_W-1:0] count_plus;
   logic [11:0]      mag_next;
   logic [31:0]      y_row, x_col;
   logic [7:0]       h_spaces, c_spaces;

   assign c          = req.in_byte;
   assign is_digit   = (c >= aetf_pkg::ZERO_CHAR) && (c <= aetf_pkg::NINE_CHAR);
   assign digit      = {{24{c[7]}}, c} - 32'd48;
   assign count_plus = count_ff + CNT_W'(1);
   assign mag_next   = ({4'd0, mag_ff} << 3) + ({4'd0, mag_ff} << 1) + {8'd0, c[3:0]};

   // cursor position: fields count from one, zero means zero
   assign y_row = (row_ff != 32'd0) ? row_ff - 32'd1 : 32'd0;
   assign x_col = (col_ff != 32'd0) ? col_ff - 32'd1 : 32'd0;

   always_comb begin
      h_spaces = 8'd0;
      if (($signed(y_row) > $signed(prev_row_ff)) && (x_col != 32'd0) && !x_col[31]) begin
         h_spaces = (x_col > {24'd0, space_limit_ff}) ? space_limit_ff : x_col[7:0];
      end
      c_spaces = (mag_ff > space_limit_ff) ? space_limit_ff : mag_ff;
   end

   always_comb begin
      mode_in     = mode_ff;
      esc_in      = esc_ff;
      store_in    = store_ff;
      count_in    = count_ff;
      prev_row_in = prev_row_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      field_in    = field_ff;
      phase_in    = phase_ff;
      mag_in      = mag_ff;
      cmd         = '0;
      cmd.body_kind = aetf_pkg::BODY_NONE;
      handle      = 1'b1;

      if (accept) begin
         if (esc_ff) begin
            esc_in = 1'b0;
            if (c == aetf_pkg::OPEN_BRACKET_CHAR) begin
               handle   = 1'b0;
               mode_in  = M_SEQ;
               count_in = '0;
               row_in   = '0;
               col_in   = '0;
               field_in = '0;
               phase_in = '0;
               mag_in   = '0;
            end else begin
               cmd.esc_lead = 1'b1;
            end
         end

         if (handle) begin
            if ((c == aetf_pkg::CR_CHAR) || (c == aetf_pkg::LF_CHAR)) begin
               if (mode_ff != M_NEWLINE) begin
                  mode_in        = M_NEWLINE;
                  cmd.crlf_pairs = 2'd1;
               end
            end else if (c == aetf_pkg::ESC_CHAR) begin
               esc_in = 1'b1;
            end else if (mode_ff == M_SEQ) begin
               if ((c >= aetf_pkg::FINAL_LOW) && (c <= aetf_pkg::FINAL_HIGH)) begin
                  mode_in = M_NORMAL;
                  case (c)
                     aetf_pkg::CMD_CURSOR_POS: begin
                        cmd.crlf_pairs = (y_row != prev_row_ff) ? 2'd1 : 2'd0;
                        if (h_spaces != 8'd0) begin
                           cmd.body_kind = aetf_pkg::BODY_SPACES;
                           cmd.body_byte = h_spaces;
                        end
                        prev_row_in = y_row;
                     end
                     aetf_pkg::CMD_CURSOR_DOWN: begin
                        cmd.crlf_pairs = 2'd2;
                     end
                     aetf_pkg::CMD_CURSOR_FWD: begin
                        if (c_spaces != 8'd0) begin
                           cmd.body_kind = aetf_pkg::BODY_SPACES;
                           cmd.body_byte = c_spaces;
                        end
                     end
                     default: begin
                     end
                  endcase
               end else begin
                  store_in[count_ff[IDX_W-1:0]] = c;
                  count_in = count_plus;

                  // row;column fields for cursor position
                  if (field_ff < 2'd2) begin
                     if (c == 8'd0) begin
                        field_in = 2'd2;
                     end else if (c == aetf_pkg::SEMICOLON_CHAR) begin
                        field_in = field_ff + 2'd1;
                     end else if (field_ff == 2'd0) begin
                        row_in = (row_ff << 3) + (row_ff << 1) + digit;
                     end else begin
                        col_in = (col_ff << 3) + (col_ff << 1) + digit;
                     end
                  end

                  // atoi-like count for cursor forward
                  case (phase_ff)
                     2'd0: begin
                        if ((c == aetf_pkg::SPACE_CHAR) ||
                            ((c >= aetf_pkg::TAB_CHAR) && (c <= aetf_pkg::CR_CHAR))) begin
                           phase_in = 2'd0;
                        end else if ((c == aetf_pkg::PLUS_CHAR) ||
                                     (c == aetf_pkg::MINUS_CHAR)) begin
                           phase_in = 2'd1;
                        end else if (is_digit) begin
                           mag_in   = {4'd0, c[3:0]};
                           phase_in = 2'd2;
                        end else begin
                           phase_in = 2'd3;
                        end
                     end
                     2'd1, 2'd2: begin
                        if (is_digit) begin
                           mag_in   = (mag_next > 12'd255) ? 8'd255 : mag_next[7:0];
                           phase_in = 2'd2;
                        end else begin
                           phase_in = 2'd3;
                        end
                     end
                     default: begin
                     end
                  endcase

                  // sequence too long: replay it raw
                  if (count_plus == CNT_W'(CODE_DEPTH)) begin
                     cmd.body_kind = aetf_pkg::BODY_DUMP;
                     count_in      = '0;
                     mode_in       = M_NORMAL;
                  end
               end
            end else begin
               if (c != 8'd0) begin
                  cmd.body_kind = aetf_pkg::BODY_BYTE;
                  cmd.body_byte = c;
               end
               mode_in = M_NORMAL;
            end
         end

         if (req.end_of_chunk) begin
            cmd.esc_tail = esc_in;
            mode_in      = M_NORMAL;
            esc_in       = 1'b0;
            count_in     = '0;
            prev_row_in  = 32'hFFFF_FFFF;
            row_in       = '0;
            col_in       = '0;
            field_in     = '0;
            phase_in     = '0;
            mag_in       = '0;
         end
      end
   end

   always_comb begin
      for (int k = 0; k < CODE_DEPTH; k++) begin
         dump[k*8 +: 8] = store_in[k];
      end
   end

   assign cmd_push = accept && (cmd.esc_lead || (cmd.crlf_pairs != 2'd0) ||
                                (cmd.body_kind != aetf_pkg::BODY_NONE) || cmd.esc_tail);

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff        <= M_NORMAL;
         esc_ff         <= 1'b0;
         count_ff       <= '0;
         prev_row_ff    <= 32'hFFFF_FFFF;
         row_ff         <= '0;
         col_ff         <= '0;
         field_ff       <= '0;
         phase_ff       <= '0;
         mag_ff         <= '0;
         space_limit_ff <= aetf_pkg::SPACE_LIMIT_RESET;
      end else begin
         mode_ff     <= mode_in;
         esc_ff      <= esc_in;
         count_ff    <= count_in;
         prev_row_ff <= prev_row_in;
         row_ff      <= row_in;
         col_ff      <= col_in;
         field_ff    <= field_in;
         phase_ff    <= phase_in;
         mag_ff      <= mag_in;
         if (csr_write) begin
            space_limit_ff <= csr_wdata;
         end
      end
   end

   always_ff @(posedge clock) begin
      store_ff <= store_in;
   end

endmodule

FILE: rtl/aetf_cmd_queue.sv
// Two-entry command queue between front and back ends.
// Generic width; depends on nothing.
module aetf_cmd_queue #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;
   logic             do_push, do_pop;

   assign full    = (count_ff == 2'd2);
   assign empty   = (count_ff == 2'd0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (do_pop) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 2'd1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

endmodule

FILE: rtl/aetf_back.sv
// Back end: expands the head command into result transactions, one a cycle while
// the output is popped, through a registered output stage. Depends on aetf_pkg.
module aetf_back #(
   parameter int CODE_DEPTH = 18
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    head_valid,
   input  aetf_pkg::cmd_type       head_cmd,
   input  logic [CODE_DEPTH*8-1:0] head_dump,
   output logic                    head_pop,
   output logic                    rsp_empty,
   input  logic                    rsp_pop,
   output aetf_pkg::rsp_type       rsp_data
);

   localparam int IDX_W = $clog2(CODE_DEPTH);

   typedef enum logic [2:0] {
      P_LEAD,
      P_CR,
      P_LF,
      P_BODY,
      P_TAIL,
      P_DONE
   } piece_type;

   // first piece of the command present at or after p
   function automatic piece_type first_from(piece_type p, aetf_pkg::cmd_type c);
      piece_type r;
      r = P_DONE;
      if ((p <= P_TAIL) && c.esc_tail) r = P_TAIL;
      if ((p <= P_BODY) && (c.body_kind != aetf_pkg::BODY_NONE)) r = P_BODY;
      if ((p <= P_CR) && (c.crlf_pairs != 2'd0)) r = P_CR;
      if ((p == P_LEAD) && c.esc_lead) r = P_LEAD;
      return r;
   endfunction

   logic              rsp_valid_ff;
   aetf_pkg::rsp_type rsp_ff;
   logic              started_ff;
   piece_type         piece_ff;
   logic              pair_ff;
   logic [IDX_W-1:0]  idx_ff;

   piece_type         cur_piece, nxt_piece;
   logic              cur_pair, nxt_pair;
   logic [IDX_W-1:0]  cur_idx, nxt_idx;
   aetf_pkg::rsp_type cur_rsp;
   logic              load;

   assign cur_piece = started_ff ? piece_ff : first_from(P_LEAD, head_cmd);
   assign cur_pair  = started_ff ? pair_ff : 1'b0;
   assign cur_idx   = started_ff ? idx_ff : '0;

   always_comb begin
      nxt_piece = P_DONE;
      nxt_pair  = cur_pair;
      nxt_idx   = cur_idx;
      cur_rsp.repeat_count = 8'd1;
      cur_rsp.out_byte     = aetf_pkg::ESC_CHAR;
      case (cur_piece)
         P_LEAD: begin
            nxt_piece = first_from(P_CR, head_cmd);
         end
         P_CR: begin
            cur_rsp.out_byte = aetf_pkg::CR_CHAR;
            nxt_piece        = P_LF;
         end
         P_LF: begin
            cur_rsp.out_byte = aetf_pkg::LF_CHAR;
            if (!cur_pair && (head_cmd.crlf_pairs == 2'd2)) begin
               nxt_piece = P_CR;
               nxt_pair  = 1'b1;
            end else begin
               nxt_piece = first_from(P_BODY, head_cmd);
            end
         end
         P_BODY: begin
            case (head_cmd.body_kind)
               aetf_pkg::BODY_SPACES: begin
                  cur_rsp.out_byte     = aetf_pkg::SPACE_CHAR;
                  cur_rsp.repeat_count = head_cmd.body_byte;
               end
               aetf_pkg::BODY_DUMP: begin
                  cur_rsp.out_byte = head_dump[cur_idx*8 +: 8];
               end
               default: begin
                  cur_rsp.out_byte = head_cmd.body_byte;
               end
            endcase
            if ((head_cmd.body_kind == aetf_pkg::BODY_DUMP) &&
                (cur_idx != IDX_W'(CODE_DEPTH - 1))) begin
               nxt_piece = P_BODY;
               nxt_idx   = cur_idx + IDX_W'(1);
            end else begin
               nxt_piece = first_from(P_TAIL, head_cmd);
            end
         end
         default: begin
            nxt_piece = P_DONE;
         end
      endcase
      cur_rsp.last_result = (nxt_piece == P_DONE);
   end

   assign load      = head_valid && (!rsp_valid_ff || rsp_pop);
   assign head_pop  = load && cur_rsp.last_result;
   assign rsp_empty = !rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         started_ff   <= 1'b0;
         piece_ff     <= P_LEAD;
         pair_ff      <= 1'b0;
         idx_ff       <= '0;
      end else if (load) begin
         rsp_valid_ff <= 1'b1;
         rsp_ff       <= cur_rsp;
         started_ff   <= !cur_rsp.last_result;
         piece_ff     <= nxt_piece;
         pair_ff      <= nxt_pair;
         idx_ff       <= nxt_idx;
      end else if (rsp_pop) begin
         rsp_valid_ff <= 1'b0;
      end
   end

endmodule

FILE: rtl/ansi_escape_text_filter.sv
// Top level of the ANSI escape text filter: front parser, command queue, back expander.
// Depends on aetf_pkg, aetf_front, aetf_cmd_queue and aetf_back.
//
//   channel   direction  handshake          payload
//   req_      in         req_push/req_full  aetf_pkg::req_type (in_byte, end_of_chunk)
//   rsp_      out        rsp_pop/rsp_empty  aetf_pkg::rsp_type (byte, count, last)
//   csr_      in         csr_write          csr_wdata = space_limit
//
// The front takes one byte per cycle while the two-entry command queue has room.
// The back emits one result transaction per cycle while rsp_pop takes them, so a byte
// with k results holds the back until all k are out: up to 4 for CR LF runs, CODE_DEPTH + 1 for an overflow dump.
// Synchronous reset clears all control state; the sequence store needs no clearing.
// req_full follows the command queue; a stalled rsp_ output register holds its value.
module ansi_escape_text_filter #(
   parameter int CODE_DEPTH = 18
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   output logic              req_full,
   input  aetf_pkg::req_type req_data,
   output logic              rsp_empty,
   input  logic              rsp_pop,
   output aetf_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [7:0]        csr_wdata
);

   localparam int CMD_W  = $bits(aetf_pkg::cmd_type);
   localparam int DUMP_W = CODE_DEPTH * 8;
   localparam int Q_W    = CMD_W + DUMP_W;

   logic              accept;
   logic              cmd_push;
   aetf_pkg::cmd_type cmd;
   logic [DUMP_W-1:0] dump;

   logic [Q_W-1:0]    head;
   logic              head_empty;
   logic              head_pop;
   aetf_pkg::cmd_type head_cmd;
   logic [DUMP_W-1:0] head_dump;

   // a byte is taken whenever the queue can take whatever it produces
   assign accept = req_push && !req_full;

   aetf_front #(
      .CODE_DEPTH(CODE_DEPTH)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .req       (req_data),
      .csr_write (csr_write),
      .csr_wdata (csr_wdata),
      .cmd_push  (cmd_push),
      .cmd       (cmd),
      .dump      (dump)
   );

   // command plus snapshot of the sequence store travel together
   aetf_cmd_queue #(
      .WIDTH(Q_W)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (cmd_push),
      .wdata ({cmd, dump}),
      .full  (req_full),
      .pop   (head_pop),
      .rdata (head),
      .empty (head_empty)
   );

   assign head_cmd  = aetf_pkg::cmd_type'(head[Q_W-1 -: CMD_W]);
   assign head_dump = head[DUMP_W-1:0];

   aetf_back #(
      .CODE_DEPTH(CODE_DEPTH)
   ) u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (!head_empty),
      .head_cmd   (head_cmd),
      .head_dump  (head_dump),
      .head_pop   (head_pop),
      .rsp_empty  (rsp_empty),
      .rsp_pop    (rsp_pop),
      .rsp_data   (rsp_data)
   );

endmodule

FILE: rtl/aetf_checker.sv
// Port-level checker for the text filter, bound to the top level.
// Depends on aetf_pkg and ansi_escape_text_filter_defines.svh.
`include "ansi_escape_text_filter_defines.svh"

module aetf_checker (
   input logic              clock,
   input logic              reset,
   input logic              rsp_empty,
   input logic              rsp_pop,
   input aetf_pkg::rsp_type rsp_data
);

   // every result carries at least one copy
`AETF_NEVER(a_count_nonzero, clock, reset, !rsp_empty && (rsp_data.repeat_count == 8'd0), "zero repeat count")

   // runs longer than one are spaces only
`AETF_NEVER(a_run_is_space, clock, reset, !rsp_empty && (rsp_data.repeat_count > 8'd1) && (rsp_data.out_byte != aetf_pkg::SPACE_CHAR), "run of non-space byte")

   // CR is always the first half of a pair, followed at once by LF
`AETF_ASSERT(a_cr_then_lf, clock, reset, (!rsp_empty && rsp_pop && (rsp_data.out_byte == aetf_pkg::CR_CHAR)) |=> (!rsp_empty && (rsp_data.out_byte == aetf_pkg::LF_CHAR)), "CR not followed by LF")

   // a stalled result transaction holds
`AETF_ASSERT(a_stall_hold, clock, reset, (!rsp_empty && !rsp_pop) |=> (!rsp_empty && $stable(rsp_data)), "stalled result changed")

endmodule

bind ansi_escape_text_filter aetf_checker u_checker (.*);

FILE: sim/aetf_run_checker.sv
// Output checker for the ANSI escape text filter: predicts (byte, count) runs per request.
// Depends on aetf_pkg; watches req_, rsp_ and csr_ ports of the DUT.
`timescale 1ns / 100ps

module aetf_run_checker #(
   parameter int CODE_DEPTH = 18
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_push,
   input  logic              req_full,
   input  aetf_pkg::req_type req_data,
   input  logic              rsp_empty,
   input  logic              rsp_pop,
   input  aetf_pkg::rsp_type rsp_data,
   input  logic              csr_write,
   input  logic [7:0]        csr_wdata,
   output int                fail_count,
   output int                pending_runs
);
   import aetf_pkg::*;

   localparam int MAX_REPORTS = 10;

   typedef enum logic [1:0] {
      MODE_TEXT,
      MODE_AFTER_NL,
      MODE_SEQ
   } parse_mode_type;

   typedef enum logic [1:0] {
      CNT_BLANKS,
      CNT_SIGN,
      CNT_DIGITS,
      CNT_DONE
   } count_phase_type;

   logic [7:0]      space_limit_q;
   parse_mode_type  mode_q;
   logic            esc_wait_q;
   logic [7:0]      seq_bytes [CODE_DEPTH];
   int              seq_count;
   logic [31:0]     prev_row;
   logic [31:0]     row_acc;
   logic [31:0]     col_acc;
   logic [1:0]      field_sel;
   count_phase_type cnt_phase;
   logic [7:0]      cnt_mag;

   rsp_type expected_runs [$];

   function void add_run(input logic [7:0] b, input logic [7:0] n);
      rsp_type r;
      r.out_byte     = b;
      r.repeat_count = n;
      r.last_result  = 1'b0;
      expected_runs.insert(expected_runs.size(), r);
   endfunction

   function void add_crlf();
      add_run(CR_CHAR, 8'd1);
      add_run(LF_CHAR, 8'd1);
   endfunction

   function void add_spaces(input logic [31:0] n);
      if (n > {24'd0, space_limit_q})
         n = {24'd0, space_limit_q};
      if (n != 0)
         add_run(SPACE_CHAR, n[7:0]);
   endfunction

   function void clear_parser();
      mode_q     = MODE_TEXT;
      esc_wait_q = 1'b0;
      seq_count  = 0;
      prev_row   = '1;
      row_acc    = '0;
      col_acc    = '0;
      field_sel  = 2'd0;
      cnt_phase  = CNT_BLANKS;
      cnt_mag    = 8'd0;
   endfunction

   function void open_seq();
      mode_q    = MODE_SEQ;
      seq_count = 0;
      row_acc   = '0;
      col_acc   = '0;
      field_sel = 2'd0;
      cnt_phase = CNT_BLANKS;
      cnt_mag   = 8'd0;
   endfunction

   // row/col fields take any byte as a digit; the C count parses like atoi
   function void feed_fields(input logic [7:0] c);
      logic [31:0] digit;
      logic [31:0] m;
      logic        is_digit;
      digit    = {{24{c[7]}}, c} - 32'd48;
      is_digit = (c >= ZERO_CHAR) && (c <= NINE_CHAR);
      if (field_sel < 2) begin
         if (c == 8'd0)
            field_sel = 2'd2;
         else if (c == SEMICOLON_CHAR)
            field_sel = field_sel + 2'd1;
         else if (field_sel == 0)
            row_acc = row_acc * 32'd10 + digit;
         else
            col_acc = col_acc * 32'd10 + digit;
      end
      case (cnt_phase)
         CNT_BLANKS: begin
            if (c == SPACE_CHAR || (c >= TAB_CHAR && c <= CR_CHAR)) begin
               cnt_phase = CNT_BLANKS;
            end else if (c == PLUS_CHAR || c == MINUS_CHAR) begin
               cnt_phase = CNT_SIGN;
            end else if (is_digit) begin
               cnt_mag   = c - ZERO_CHAR;
               cnt_phase = CNT_DIGITS;
            end else begin
               cnt_phase = CNT_DONE;
            end
         end
         CNT_SIGN, CNT_DIGITS: begin
            if (is_digit) begin
               m         = {24'd0, cnt_mag} * 32'd10 + {24'd0, c - ZERO_CHAR};
               cnt_mag   = (m > 32'd255) ? 8'd255 : m[7:0];
               cnt_phase = CNT_DIGITS;
            end else begin
               cnt_phase = CNT_DONE;
            end
         end
         default: ;
      endcase
   endfunction

   function void finish_seq(input logic [7:0] c);
      logic [31:0] y;
      logic [31:0] x;
      if (c == CMD_CURSOR_POS) begin
         y = (row_acc != 0) ? row_acc - 32'd1 : 32'd0;
         x = (col_acc != 0) ? col_acc - 32'd1 : 32'd0;
         if (y != prev_row)
            add_crlf();
         if ($signed(y) > $signed(prev_row) && x != 0 && !x[31])
            add_spaces(x);
         prev_row = y;
      end else if (c == CMD_CURSOR_DOWN) begin
         add_crlf();
         add_crlf();
      end else if (c == CMD_CURSOR_FWD) begin
         add_spaces({24'd0, cnt_mag});
      end
      mode_q = MODE_TEXT;
   endfunction

   function void parse_byte(input logic [7:0] c);
      if (c == CR_CHAR || c == LF_CHAR) begin
         if (mode_q != MODE_AFTER_NL) begin
            mode_q = MODE_AFTER_NL;
            add_crlf();
         end
      end else if (c == ESC_CHAR) begin
         esc_wait_q = 1'b1;
      end else if (mode_q == MODE_SEQ) begin
         if (c >= FINAL_LOW && c <= FINAL_HIGH) begin
            finish_seq(c);
         end else begin
            seq_bytes[seq_count] = c;
            seq_count = seq_count + 1;
            feed_fields(c);
            // overflow: the gathered bytes go out raw
            if (seq_count >= CODE_DEPTH) begin
               for (int k = 0; k < CODE_DEPTH; k++)
                  add_run(seq_bytes[k], 8'd1);
               seq_count = 0;
               mode_q    = MODE_TEXT;
            end
         end
      end else begin
         if (c != 8'd0)
            add_run(c, 8'd1);
         mode_q = MODE_TEXT;
      end
   endfunction

   function void predict_text_runs(input req_type item);
      int base;
      base = expected_runs.size();
      if (esc_wait_q) begin
         esc_wait_q = 1'b0;
         if (item.in_byte == OPEN_BRACKET_CHAR) begin
            open_seq();
         end else begin
            add_run(ESC_CHAR, 8'd1);
            parse_byte(item.in_byte);
         end
      end else begin
         parse_byte(item.in_byte);
      end
      if (item.end_of_chunk) begin
         if (esc_wait_q)
            add_run(ESC_CHAR, 8'd1);
         clear_parser();
      end
      if (expected_runs.size() > base)
         expected_runs[expected_runs.size() - 1].last_result = 1'b1;
   endfunction

   function void check_run(input rsp_type got);
      rsp_type want;
      if (expected_runs.size() == 0) begin
         if (fail_count < MAX_REPORTS)
            $display("unexpected rsp transaction: byte %0d count %0d last %0b",
                     got.out_byte, got.repeat_count, got.last_result);
         fail_count = fail_count + 1;
      end else begin
         want = expected_runs.pop_front();
         if (got.out_byte !== want.out_byte || got.repeat_count !== want.repeat_count ||
             got.last_result !== want.last_result) begin
            if (fail_count < MAX_REPORTS)
               $display({"rsp mismatch: expected byte %0d count %0d last %0b, ",
                         "got byte %0d count %0d last %0b"},
                        want.out_byte, want.repeat_count, want.last_result,
                        got.out_byte, got.repeat_count, got.last_result);
            fail_count = fail_count + 1;
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         space_limit_q = SPACE_LIMIT_RESET;
         clear_parser();
         expected_runs.delete();
      end else begin
         if (csr_write)
            space_limit_q = csr_wdata;
         if (req_push && !req_full)
            predict_text_runs(req_data);
         if (rsp_pop && !rsp_empty)
            check_run(rsp_data);
      end
      pending_runs <= expected_runs.size();
   end

endmodule

FILE: sim/tb_ansi_escape_text_filter.sv
// Testbench top for the ANSI escape text filter: clock, reset, stimulus and verdict.
// Depends on aetf_pkg, ansi_escape_text_filter and aetf_run_checker.
`timescale 1ns / 100ps

module tb_ansi_escape_text_filter;
   import aetf_pkg::*;

   localparam int CODE_DEPTH     = 18;
   localparam int PHASE_BYTES    = 88;       // random bytes per space_limit setting
   localparam int SETTLE_CYCLES  = 40;       // settle time after the last predicted run
   localparam int CYCLE_LIMIT    = 1000000;  // hard stop, far above the longest expected run
   localparam int NUM_SETTINGS   = 5;

   logic       clock;
   logic       reset;
   logic       req_push;
   logic       req_full;
   req_type    req_data;
   logic       rsp_empty;
   logic       rsp_pop;
   rsp_type    rsp_data;
   logic       csr_write;
   logic [7:0] csr_wdata;

   int fail_count;
   int pending_runs;
   int cycle_count = 0;
   int pop_hold    = 0;
   bit smooth;                // phase with no idling on either side

   req_type    byte_stream [$];
   logic [7:0] limit_plan [NUM_SETTINGS];

   ansi_escape_text_filter #(
      .CODE_DEPTH(CODE_DEPTH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_push (req_push),
      .req_full (req_full),
      .req_data (req_data),
      .rsp_empty(rsp_empty),
      .rsp_pop  (rsp_pop),
      .rsp_data (rsp_data),
      .csr_write(csr_write),
      .csr_wdata(csr_wdata)
   );

   aetf_run_checker #(
      .CODE_DEPTH(CODE_DEPTH)
   ) checker_i (
      .clock       (clock),
      .reset       (reset),
      .req_push    (req_push),
      .req_full    (req_full),
      .req_data    (req_data),
      .rsp_empty   (rsp_empty),
      .rsp_pop     (rsp_pop),
      .rsp_data    (rsp_data),
      .csr_write   (csr_write),
      .csr_wdata   (csr_wdata),
      .fail_count  (fail_count),
      .pending_runs(pending_runs)
   );

   // 2 ns period
   always begin
      clock = 1'b1;
      #1;
      clock = 1'b0;
      #1;
   end

   // hard stop: a hung handshake ends the run as a failure
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("TB_ERROR");
         $finish;
      end
   end

   // idle length: mostly short, now and then a long one
   function int pick_gap();
      if ($urandom_range(0, 15) == 0)
         return $urandom_range(8, 20);
      return $urandom_range(1, 3);
   endfunction

   // result side: pop high by default, with random stalls outside smooth phases
   always @(posedge clock) begin
      if (reset) begin
         rsp_pop  <= 1'b0;
         pop_hold <= 0;
      end else if (pop_hold != 0) begin
         rsp_pop  <= 1'b0;
         pop_hold <= pop_hold - 1;
      end else begin
         rsp_pop <= 1'b1;
         if (!smooth && $urandom_range(0, 3) == 0)
            pop_hold <= pick_gap();
      end
   end

   // ---------------------------------------------------------------
   // byte stream builders
   // ---------------------------------------------------------------
   task put(input logic [7:0] b, input logic eoc);
      req_type r;
      r.in_byte      = b;
      r.end_of_chunk = eoc;
      byte_stream.insert(byte_stream.size(), r);
   endtask

   // random bytes close a chunk now and then, which also cuts sequences short
   task put_rand(input logic [7:0] b);
      put(b, $urandom_range(0, 59) == 0);
   endtask

   task put_csi();
      put_rand(ESC_CHAR);
      put_rand(OPEN_BRACKET_CHAR);
   endtask

   // mostly short numbers; a few long enough to wrap the 32-bit fields
   task put_number();
      int nd;
      nd = ($urandom_range(0, 9) == 0) ? $urandom_range(8, 12) : $urandom_range(0, 3);
      repeat (nd) put_rand(ZERO_CHAR + 8'($urandom_range(0, 9)));
   endtask

   // non-final byte for inside a sequence; no CR, LF or ESC here
   function logic [7:0] seq_filler();
      logic [7:0] b;
      case ($urandom_range(0, 6))
         0, 1: b = ZERO_CHAR + 8'($urandom_range(0, 9));
         2: b = SEMICOLON_CHAR;
         3: b = 8'd0;
         4: b = 8'($urandom_range(128, 255));
         5: b = 8'($urandom_range(32, 64));
         default: begin
            b = 8'($urandom_range(0, 31));
            if (b == CR_CHAR || b == LF_CHAR || b == ESC_CHAR)
               b = TAB_CHAR;
         end
      endcase
      return b;
   endfunction

   // short directed stream at the reset value of space_limit
   task build_directed();
      put(8'h41, 1'b0);                 // plain byte
      put(8'h00, 1'b0);                 // zero byte is dropped
      put(8'hFF, 1'b0);                 // top of the byte range
      put(CR_CHAR, 1'b0);               // CR LF CR collapses to one pair
      put(LF_CHAR, 1'b0);
      put(CR_CHAR, 1'b0);
      put(ESC_CHAR, 1'b0);              // ESC without '[' goes out raw
      put(8'h78, 1'b0);
      put(ESC_CHAR, 1'b0);              // cursor position row 3 col 5
      put(OPEN_BRACKET_CHAR, 1'b0);
      put(ZERO_CHAR + 8'd3, 1'b0);
      put(SEMICOLON_CHAR, 1'b0);
      put(ZERO_CHAR + 8'd5, 1'b0);
      put(CMD_CURSOR_POS, 1'b0);
      put(ESC_CHAR, 1'b0);              // cursor down: two CR LF pairs
      put(OPEN_BRACKET_CHAR, 1'b0);
      put(CMD_CURSOR_DOWN, 1'b0);
      put(ESC_CHAR, 1'b0);              // cursor forward with a sign
      put(OPEN_BRACKET_CHAR, 1'b0);
      put(MINUS_CHAR, 1'b0);
      put(ZERO_CHAR + 8'd9, 1'b0);
      put(CMD_CURSOR_FWD, 1'b0);
      put(ESC_CHAR, 1'b0);              // other final letter is dropped
      put(OPEN_BRACKET_CHAR, 1'b0);
      put(8'h7A, 1'b0);
      put(ESC_CHAR, 1'b1);              // ESC closing a chunk goes out raw
   endtask

   // one burst: mostly well-formed sequences with random content, some noise
   task build_burst();
      int kind;
      int n;
      kind = $urandom_range(0, 19);
      if (kind < 3) begin
         n = $urandom_range(1, 6);
         repeat (n) put_rand(8'($urandom_range(0, 255)));
      end else if (kind < 5) begin
         n = $urandom_range(1, 3);
         repeat (n) put_rand($urandom_range(0, 1) ? CR_CHAR : LF_CHAR);
      end else if (kind < 11) begin
         // cursor position, sometimes with odd bytes in the fields
         put_csi();
         put_number();
         if ($urandom_range(0, 4) != 0) begin
            put_rand(SEMICOLON_CHAR);
            put_number();
         end
         if ($urandom_range(0, 5) == 0)
            put_rand(seq_filler());
         put_rand(CMD_CURSOR_POS);
      end else if (kind < 14) begin
         // cursor forward: blanks, sign, digits
         put_csi();
         n = $urandom_range(0, 2);
         repeat (n) put_rand($urandom_range(0, 1) ? SPACE_CHAR : TAB_CHAR);
         case ($urandom_range(0, 3))
            0: put_rand(PLUS_CHAR);
            1: put_rand(MINUS_CHAR);
            default: ;
         endcase
         n = $urandom_range(0, 4);
         repeat (n) put_rand(ZERO_CHAR + 8'($urandom_range(0, 9)));
         if ($urandom_range(0, 5) == 0)
            put_rand(seq_filler());
         put_rand(CMD_CURSOR_FWD);
      end else if (kind < 15) begin
         put_csi();
         if ($urandom_range(0, 1))
            put_number();
         put_rand(CMD_CURSOR_DOWN);
      end else if (kind < 16) begin
         put_csi();
         put_number();
         put_rand(8'($urandom_range(FINAL_LOW, FINAL_HIGH)));
      end else if (kind < 18) begin
         // overflow of the sequence store
         put_csi();
         n = $urandom_range(CODE_DEPTH, CODE_DEPTH + 3);
         repeat (n) put_rand(seq_filler());
      end else if (kind < 19) begin
         put_rand(ESC_CHAR);
         put_rand(8'($urandom_range(0, 255)));
      end else begin
         // broken sequence: ends on anything, CR, LF and ESC included
         put_csi();
         n = $urandom_range(0, 6);
         repeat (n) put_rand(seq_filler());
         case ($urandom_range(0, 3))
            0: put_rand(CR_CHAR);
            1: put_rand(LF_CHAR);
            2: put_rand(ESC_CHAR);
            default: put_rand(8'($urandom_range(0, 255)));
         endcase
      end
   endtask

   // ---------------------------------------------------------------
   // channel drivers
   // ---------------------------------------------------------------

   // one req transaction; the caller stands on a rising edge
   task send_item(input req_type item);
      int gap;
      gap = (!smooth && $urandom_range(0, 2) == 0) ? pick_gap() : 0;
      if (gap > 0) begin
         req_push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_push <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (req_full)
         @(posedge clock);
   endtask

   task send_stream();
      while (byte_stream.size() != 0)
         send_item(byte_stream.pop_front());
      req_push <= 1'b0;
   endtask

   // wait out all predicted runs, then let any run-free bytes clear the pipe
   task drain();
      @(posedge clock);
      while (pending_runs != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task write_space_limit(input logic [7:0] v);
      csr_write <= 1'b1;
      csr_wdata <= v;
      @(posedge clock);
      csr_write <= 1'b0;
   endtask

   initial begin
      req_push  = 1'b0;
      req_data  = '0;
      csr_write = 1'b0;
      csr_wdata = 8'd0;
      reset     = 1'b1;
      smooth    = 1'b0;

      limit_plan[0] = 8'd255;
      limit_plan[1] = 8'd0;
      limit_plan[2] = 8'd1;
      limit_plan[3] = 8'($urandom_range(2, 254));
      limit_plan[4] = SPACE_LIMIT_RESET;

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      build_directed();
      send_stream();
      drain();

      // one random phase per space_limit setting, block idle around each write
      for (int p = 0; p < NUM_SETTINGS; p++) begin
         write_space_limit(limit_plan[p]);
         smooth = ($urandom_range(0, 3) == 0);
         while (byte_stream.size() < PHASE_BYTES)
            build_burst();
         send_stream();
         drain();
      end

      if (fail_count == 0 && pending_runs == 0) begin
         $display("TB_OK");
      end else begin
         $display("TB_ERROR");
      end
      $finish;
   end

endmodule

FILE: files.f
+incdir+rtl
rtl/aetf_pkg.sv
rtl/aetf_front.sv
rtl/aetf_cmd_queue.sv
rtl/aetf_back.sv
rtl/ansi_escape_text_filter.sv
rtl/aetf_checker.sv
sim/aetf_run_checker.sv
sim/tb_ansi_escape_text_filter.sv
